// ===== src/ubx_nav_position_deframer_core_assert.svh =====
// Assertion macros shared by the UBX deframer RTL.
`ifndef UBX_NAV_POSITION_DEFRAMER_CORE_ASSERT_SVH
`define UBX_NAV_POSITION_DEFRAMER_CORE_ASSERT_SVH
`ifndef SYNTH
// Property must hold at every clock out of reset.
`define UBX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true out of reset.
`define UBX_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define UBX_ASSERT(lbl, prop, msg)
`define UBX_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== src/ubxnav_pkg.sv =====
// Constants and types for the UBX navigation deframer.
`default_nettype none
package ubxnav_pkg;

    // Frame header bytes
    localparam logic [7:0] UBX_SYNC_1    = 8'hB5;
    localparam logic [7:0] UBX_SYNC_2    = 8'h62;
    localparam logic [7:0] UBX_CLASS_NAV = 8'h01;
    localparam logic [7:0] UBX_ID_POS    = 8'h02;
    localparam logic [7:0] UBX_ID_STATUS = 8'h03;

    // Fix types that count as usable
    localparam logic [7:0] FIX_2D      = 8'h02;
    localparam logic [7:0] FIX_3D      = 8'h03;
    localparam logic [7:0] FIX_GNSS_DR = 8'h04;

    // Body lengths: length field, payload, two check bytes
    localparam int POS_BODY_LEN  = 32;
    localparam int STAT_BODY_LEN = 20;
    localparam int CNT_W         = 5;

    // Index of CK_A inside the body
    localparam logic [CNT_W-1:0] POS_CKA_IDX  = CNT_W'(POS_BODY_LEN - 2);
    localparam logic [CNT_W-1:0] STAT_CKA_IDX = CNT_W'(STAT_BODY_LEN - 2);

    // Body byte positions of captured fields
    localparam logic [CNT_W-1:0] LON_FIRST    = CNT_W'(6);
    localparam logic [CNT_W-1:0] LON_LAST     = CNT_W'(9);
    localparam logic [CNT_W-1:0] LAT_FIRST    = CNT_W'(10);
    localparam logic [CNT_W-1:0] LAT_LAST     = CNT_W'(13);
    localparam logic [CNT_W-1:0] HGT_FIRST    = CNT_W'(18);
    localparam logic [CNT_W-1:0] HGT_LAST     = CNT_W'(21);
    localparam logic [CNT_W-1:0] FIX_TYPE_POS = CNT_W'(6);
    localparam logic [CNT_W-1:0] FIX_FLAG_POS = CNT_W'(7);

    // Output word layout
    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int HGT_W   = 32;
    localparam int FIELD_W = LAT_W + LON_W + HGT_W;
    localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;

    typedef struct packed {
        logic signed [LAT_W-1:0] latitude;
        logic signed [LON_W-1:0] longitude;
        logic signed [HGT_W-1:0] height_msl;
        logic                    fix_ok;
    } nav_payload_t;

    typedef struct packed {
        logic         valid;
        nav_payload_t data;
    } nav_result_t;

endpackage
`default_nettype wire

// ===== src/ubxnav_parser.sv =====
// Byte-wise UBX frame parser with Fletcher-8 check and field capture.
`default_nettype none
`include "ubx_nav_position_deframer_core_assert.svh"
module ubxnav_parser
    import ubxnav_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    input  wire logic [7:0]  byte_data,
    output nav_result_t      res
);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_BODY
    } phase_t;

    phase_t           phase_reg,   phase_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic             kind_reg,    kind_next;     // 1 = position, 0 = status
    logic [7:0]       sum_a_reg,   sum_a_next;
    logic [7:0]       sum_b_reg,   sum_b_next;
    logic [7:0]       ck_a_reg,    ck_a_next;
    logic [31:0]      lat_reg,     lat_next;
    logic [31:0]      lon_reg,     lon_next;
    logic [31:0]      hgt_reg,     hgt_next;
    logic [7:0]       fix_type_reg, fix_type_next;
    logic             fix_flag_reg, fix_flag_next;
    logic             fix_ok_reg,  fix_ok_next;

    logic [7:0]       sum_a_add;
    logic [7:0]       sum_b_add;
    logic [CNT_W-1:0] cka_idx;
    logic             check_pass;
    logic             good_fix;
    logic             res_valid;

    // Running Fletcher sums with this byte folded in
    assign sum_a_add = sum_a_reg + byte_data;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign cka_idx   = kind_reg ? POS_CKA_IDX : STAT_CKA_IDX;
    assign check_pass = (ck_a_reg == sum_a_reg) && (byte_data == sum_b_reg);
    assign good_fix  = ((fix_type_reg == FIX_2D) || (fix_type_reg == FIX_3D) ||
                        (fix_type_reg == FIX_GNSS_DR)) && fix_flag_reg;

    // Next-state logic for one accepted word
    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        kind_next     = kind_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        ck_a_next     = ck_a_reg;
        lat_next      = lat_reg;
        lon_next      = lon_reg;
        hgt_next      = hgt_reg;
        fix_type_next = fix_type_reg;
        fix_flag_next = fix_flag_reg;
        fix_ok_next   = fix_ok_reg;
        res_valid     = 1'b0;
        if (byte_valid)
        begin
            case (phase_reg)
                PH_SYNC1:
                begin
                    if (byte_data == UBX_SYNC_1)
                    begin
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    phase_next = (byte_data == UBX_SYNC_2) ? PH_CLASS : PH_SYNC1;
                end
                PH_CLASS:
                begin
                    if (byte_data == UBX_CLASS_NAV)
                    begin
                        // sums restart at the class byte
                        sum_a_next = byte_data;
                        sum_b_next = byte_data;
                        phase_next = PH_ID;
                    end
                    else
                    begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_ID:
                begin
                    if ((byte_data == UBX_ID_POS) || (byte_data == UBX_ID_STATUS))
                    begin
                        kind_next  = (byte_data == UBX_ID_POS);
                        sum_a_next = sum_a_add;
                        sum_b_next = sum_b_add;
                        count_next = '0;
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_BODY:
                begin
                    if (count_reg < cka_idx)
                    begin
                        // length field and payload
                        sum_a_next = sum_a_add;
                        sum_b_next = sum_b_add;
                        if (kind_reg)
                        begin
                            if ((count_reg >= LON_FIRST) && (count_reg <= LON_LAST))
                            begin
                                lon_next = {byte_data, lon_reg[31:8]};
                            end
                            else if ((count_reg >= LAT_FIRST) && (count_reg <= LAT_LAST))
                            begin
                                lat_next = {byte_data, lat_reg[31:8]};
                            end
                            else if ((count_reg >= HGT_FIRST) && (count_reg <= HGT_LAST))
                            begin
                                hgt_next = {byte_data, hgt_reg[31:8]};
                            end
                        end
                        else
                        begin
                            if (count_reg == FIX_TYPE_POS)
                            begin
                                fix_type_next = byte_data;
                            end
                            else if (count_reg == FIX_FLAG_POS)
                            begin
                                fix_flag_next = byte_data[0];
                            end
                        end
                        count_next = count_reg + 1'b1;
                    end
                    else if (count_reg == cka_idx)
                    begin
                        ck_a_next  = byte_data;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        // CK_B closes the frame
                        phase_next = PH_SYNC1;
                        count_next = '0;
                        if (check_pass)
                        begin
                            if (kind_reg)
                            begin
                                res_valid = 1'b1;
                            end
                            else
                            begin
                                fix_ok_next = good_fix;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_SYNC1;
                end
            endcase
        end
    end

    // Result fields come straight from the captures
    assign res.valid           = res_valid;
    assign res.data.latitude   = lat_reg[LAT_W-1:0];
    assign res.data.longitude  = lon_reg;
    assign res.data.height_msl = hgt_reg;
    assign res.data.fix_ok     = fix_ok_reg;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SYNC1;
            count_reg    <= '0;
            kind_reg     <= 1'b0;
            sum_a_reg    <= '0;
            sum_b_reg    <= '0;
            ck_a_reg     <= '0;
            lat_reg      <= '0;
            lon_reg      <= '0;
            hgt_reg      <= '0;
            fix_type_reg <= '0;
            fix_flag_reg <= 1'b0;
            fix_ok_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            kind_reg     <= kind_next;
            sum_a_reg    <= sum_a_next;
            sum_b_reg    <= sum_b_next;
            ck_a_reg     <= ck_a_next;
            lat_reg      <= lat_next;
            lon_reg      <= lon_next;
            hgt_reg      <= hgt_next;
            fix_type_reg <= fix_type_next;
            fix_flag_reg <= fix_flag_next;
            fix_ok_reg   <= fix_ok_next;
        end
    end

    `UBX_ASSERT(a_count_idle, (phase_reg != PH_BODY) |-> (count_reg == '0), "count left nonzero outside body")
    `UBX_ASSERT(a_res_ends_frame, res.valid |=> (phase_reg == PH_SYNC1), "result without frame end")
    `UBX_ASSERT(a_res_pos_only, res.valid |-> (kind_reg && (phase_reg == PH_BODY)), "result from non-position frame")

endmodule
`default_nettype wire

// ===== src/ubx_nav_position_deframer_core.sv =====
// Top level of the UBX navigation position deframer.
`default_nettype none
`include "ubx_nav_position_deframer_core_assert.svh"
// Takes one received serial byte per word on the slave stream and emits one word per
// position frame (class 01, id 02) whose Fletcher-8 check passes, carrying latitude,
// longitude and height; status frames (id 03) that pass update the fix flag sent in
// tuser. A byte can be taken every cycle while the skid register is empty. An output
// register plus one skid register decouple the sides; s_tready drops only while the
// skid register holds a word.
module ubx_nav_position_deframer_core
    import ubxnav_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] rx_byte
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [30:0] latitude, [62:31] longitude,
                                               // [94:63] height_msl, rest zero
    output logic                    m_tuser    // [0] fix_ok
);

    nav_result_t  res;
    logic         accept;
    logic         pop;

    logic         out_valid_reg,  out_valid_next;
    nav_payload_t out_data_reg,   out_data_next;
    logic         skid_valid_reg, skid_valid_next;
    nav_payload_t skid_data_reg,  skid_data_next;

    assign accept = s_tvalid && s_tready;

    ubxnav_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (accept),
        .byte_data  (s_tdata),
        .res        (res)
    );

    // Output register and skid register
    assign pop = out_valid_reg && m_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (skid_valid_reg)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res.valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res.data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W - FIELD_W){1'b0}}, out_data_reg.height_msl,
                       out_data_reg.longitude, out_data_reg.latitude};
    assign m_tuser  = out_data_reg.fix_ok;

    `UBX_ASSERT(a_skid_implies_out, skid_valid_reg |-> out_valid_reg, "skid full with output empty")
    `UBX_ASSERT(a_stall_to_skid, (out_valid_reg && !m_tready && !skid_valid_reg && res.valid) |=> skid_valid_reg, "stalled result lost")
    `UBX_ASSERT(a_skid_source, $rose(skid_valid_reg) |-> $past(res.valid), "skid filled without a result")

endmodule
`default_nettype wire

// ===== dv/ubx_nav_position_deframer_core_tb.sv =====
// Self-checking testbench for the UBX navigation position deframer core.
module ubx_nav_position_deframer_core_tb;
    import ubxnav_pkg::*;

    localparam int IDLE_LIMIT   = 1000;   // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 10;
    localparam int TOTAL_BYTES  = 1650;

    // Length field values a well-formed frame carries
    localparam logic [15:0] POS_LEN_FIELD  = 16'(POS_BODY_LEN - 4);
    localparam logic [15:0] STAT_LEN_FIELD = 16'(STAT_BODY_LEN - 4);

    // Header bytes that do not belong to a position or status frame
    localparam logic [7:0] JUNK_CLASS = 8'h07;
    localparam logic [7:0] JUNK_ID    = 8'h09;

    // Fix types that do not count as usable
    localparam logic [7:0] FIX_NONE      = 8'h00;
    localparam logic [7:0] FIX_TIME_ONLY = 8'h05;

    typedef enum logic [2:0] {PH_HUNT, PH_SYNC2, PH_CLASS, PH_ID, PH_BODY} parse_ph_t;
    typedef enum logic [1:0] {FR_NONE, FR_POS, FR_STATUS} frame_sel_t;
    typedef enum logic [1:0] {CK_GOOD, CK_BAD_A, CK_BAD_B, CK_BAD_BOTH} ck_fault_t;

    // One stimulus row: junk lead bytes, then an optional frame
    typedef struct {
        frame_sel_t  kind;
        logic [31:0] lead;       // lowest byte goes first
        int          n_lead;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [31:0] hgt;
        logic [7:0]  fix_type;
        logic [7:0]  flags;
        logic [15:0] len_field;
        ck_fault_t   fault;
        bit          typed;      // expectation given in the row itself
        bit          exp_hit;
        logic [30:0] exp_lat;
        bit          exp_fix;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;

    // Side info travelling with each driven byte
    logic               drv_typed;
    logic               drv_last;
    logic               drv_exp_hit;
    nav_payload_t       drv_exp;

    nav_payload_t       fix_q[$];        // position fixes still to come out
    stim_row_t          dir_rows[$];
    logic [7:0]         tx_bytes[$];
    logic [7:0]         hdr_set[5];
    int                 err_count   = 0;
    int                 idle_cycles = 0;
    bit                 src_calm    = 1'b0;
    bit                 sink_calm   = 1'b0;

    // Parser mirror
    parse_ph_t          prs_phase   = PH_HUNT;
    logic [CNT_W-1:0]   body_idx    = '0;
    logic               is_pos      = 1'b0;
    logic [7:0]         fl_a        = '0;
    logic [7:0]         fl_b        = '0;
    logic [7:0]         cka_rx      = '0;
    logic [31:0]        lat_sr      = '0;
    logic [31:0]        lon_sr      = '0;
    logic [31:0]        hgt_sr      = '0;
    logic [7:0]         fix_type_rx = '0;
    logic               fix_flag_rx = 1'b0;
    logic               fix_good    = 1'b0;

    ubx_nav_position_deframer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Advance the parser mirror by one byte; returns 1 when a position fix comes out
    function automatic bit nav_decode_byte(input logic [7:0] b, output nav_payload_t rec);
        logic [CNT_W-1:0] cka_idx;
        bit               emit;
        emit    = 1'b0;
        rec     = '0;
        cka_idx = is_pos ? POS_CKA_IDX : STAT_CKA_IDX;
        case (prs_phase)
            PH_HUNT:
                if (b == UBX_SYNC_1)
                    prs_phase = PH_SYNC2;
            PH_SYNC2:
                prs_phase = (b == UBX_SYNC_2) ? PH_CLASS : PH_HUNT;
            PH_CLASS:
                if (b == UBX_CLASS_NAV)
                begin
                    fl_a      = b;
                    fl_b      = b;
                    prs_phase = PH_ID;
                end
                else
                    prs_phase = PH_HUNT;
            PH_ID:
                if (b == UBX_ID_POS || b == UBX_ID_STATUS)
                begin
                    is_pos    = (b == UBX_ID_POS);
                    fl_a      = fl_a + b;
                    fl_b      = fl_b + fl_a;
                    body_idx  = '0;
                    prs_phase = PH_BODY;
                end
                else
                    prs_phase = PH_HUNT;
            PH_BODY:
            begin
                if (body_idx < cka_idx)
                begin
                    fl_a = fl_a + b;
                    fl_b = fl_b + fl_a;
                    if (is_pos)
                    begin
                        if (body_idx >= LON_FIRST && body_idx <= LON_LAST)
                            lon_sr = {b, lon_sr[31:8]};
                        else if (body_idx >= LAT_FIRST && body_idx <= LAT_LAST)
                            lat_sr = {b, lat_sr[31:8]};
                        else if (body_idx >= HGT_FIRST && body_idx <= HGT_LAST)
                            hgt_sr = {b, hgt_sr[31:8]};
                    end
                    else if (body_idx == FIX_TYPE_POS)
                        fix_type_rx = b;
                    else if (body_idx == FIX_FLAG_POS)
                        fix_flag_rx = b[0];
                    body_idx = body_idx + 1'b1;
                end
                else if (body_idx == cka_idx)
                begin
                    cka_rx   = b;
                    body_idx = body_idx + 1'b1;
                end
                else
                begin
                    // CK_B closes the frame, pass or fail
                    prs_phase = PH_HUNT;
                    body_idx  = '0;
                    if (cka_rx == fl_a && b == fl_b)
                    begin
                        if (is_pos)
                        begin
                            emit           = 1'b1;
                            rec.latitude   = lat_sr[LAT_W-1:0];
                            rec.longitude  = lon_sr;
                            rec.height_msl = hgt_sr;
                            rec.fix_ok     = fix_good;
                        end
                        else
                            fix_good = (fix_type_rx == FIX_2D || fix_type_rx == FIX_3D ||
                                        fix_type_rx == FIX_GNSS_DR) && fix_flag_rx;
                    end
                end
            end
            default:
                prs_phase = PH_HUNT;
        endcase
        return emit;
    endfunction

    function automatic void add_row(input frame_sel_t kind, input logic [31:0] lead,
                                    input int n_lead, input logic [31:0] lat,
                                    input logic [31:0] lon, input logic [31:0] hgt,
                                    input logic [7:0] fix_type, input logic [7:0] flags,
                                    input logic [15:0] len_field, input ck_fault_t fault,
                                    input bit typed, input bit exp_hit,
                                    input logic [30:0] exp_lat, input bit exp_fix);
        stim_row_t r;
        r.kind      = kind;
        r.lead      = lead;
        r.n_lead    = n_lead;
        r.lat       = lat;
        r.lon       = lon;
        r.hgt       = hgt;
        r.fix_type  = fix_type;
        r.flags     = flags;
        r.len_field = len_field;
        r.fault     = fault;
        r.typed     = typed;
        r.exp_hit   = exp_hit;
        r.exp_lat   = exp_lat;
        r.exp_fix   = exp_fix;
        dir_rows.push_back(r);
    endfunction

    // Lay out lead bytes and the frame, with Fletcher-8 over class through payload
    function automatic void build_frame(input stim_row_t r, input bit rand_fill);
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        logic [7:0] v;
        int         blen;
        int         i;
        tx_bytes.delete();
        for (i = 0; i < r.n_lead; i++)
            tx_bytes.push_back(r.lead[8*i +: 8]);
        if (r.kind == FR_NONE)
            return;
        blen = (r.kind == FR_POS) ? POS_BODY_LEN : STAT_BODY_LEN;
        v    = (r.kind == FR_POS) ? UBX_ID_POS : UBX_ID_STATUS;
        tx_bytes.push_back(UBX_SYNC_1);
        tx_bytes.push_back(UBX_SYNC_2);
        tx_bytes.push_back(UBX_CLASS_NAV);
        tx_bytes.push_back(v);
        ck_a = UBX_CLASS_NAV + v;
        ck_b = UBX_CLASS_NAV + ck_a;
        for (i = 0; i < blen - 2; i++)
        begin
            v = rand_fill ? 8'($urandom) : 8'(i);
            if (i < 2)
                v = r.len_field[8*i +: 8];
            else if (r.kind == FR_POS)
            begin
                if (i >= int'(LON_FIRST) && i <= int'(LON_LAST))
                    v = r.lon[8*(i-int'(LON_FIRST)) +: 8];
                else if (i >= int'(LAT_FIRST) && i <= int'(LAT_LAST))
                    v = r.lat[8*(i-int'(LAT_FIRST)) +: 8];
                else if (i >= int'(HGT_FIRST) && i <= int'(HGT_LAST))
                    v = r.hgt[8*(i-int'(HGT_FIRST)) +: 8];
            end
            else if (i == int'(FIX_TYPE_POS))
                v = r.fix_type;
            else if (i == int'(FIX_FLAG_POS))
                v = r.flags;
            tx_bytes.push_back(v);
            ck_a = ck_a + v;
            ck_b = ck_b + ck_a;
        end
        if (r.fault == CK_BAD_A || r.fault == CK_BAD_BOTH)
            ck_a = ck_a ^ 8'($urandom_range(1, 255));
        if (r.fault == CK_BAD_B || r.fault == CK_BAD_BOTH)
            ck_b = ck_b ^ 8'($urandom_range(1, 255));
        tx_bytes.push_back(ck_a);
        tx_bytes.push_back(ck_b);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 1000));
            3: return -32'($urandom_range(0, 1000));
            default: return 32'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %h want %h", $time, what, got, want);
        err_count++;
    endtask

    // Present one byte after a random gap and hold it until taken
    task automatic send_byte(input logic [7:0] b, input bit typed, input bit last_b,
                             input bit hit, input nav_payload_t exp_rec);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 39) == 0)
            src_calm = !src_calm;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= b;
        drv_typed   <= typed;
        drv_last    <= last_b;
        drv_exp_hit <= hit;
        drv_exp     <= exp_rec;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic play_row(input stim_row_t r, input bit rand_fill);
        nav_payload_t exp_rec;
        int           k;
        exp_rec.latitude   = r.exp_lat;
        exp_rec.longitude  = r.lon;
        exp_rec.height_msl = r.hgt;
        exp_rec.fix_ok     = r.exp_fix;
        build_frame(r, rand_fill);
        for (k = 0; k < tx_bytes.size(); k++)
            send_byte(tx_bytes[k], r.typed, k == tx_bytes.size() - 1, r.exp_hit, exp_rec);
    endtask

    // Sink: random stall before each word
    initial
    begin
        int n;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            n = sink_calm ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 39) == 0)
                sink_calm = !sink_calm;
            if (n != 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
            @(negedge clk);
        end
    end

    // Both handshakes sampled at the rising edge: predict, check, watchdog
    always @(posedge clk)
    begin
        nav_payload_t pred;
        nav_payload_t seen;
        nav_payload_t want;
        bit           hit;
        bit           moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (s_tvalid && s_tready)
            begin
                moved = 1'b1;
                hit   = nav_decode_byte(s_tdata, pred);
                if (drv_typed)
                begin
                    if (drv_last && drv_exp_hit)
                    begin
                        fix_q.push_back(drv_exp);
                    end
                end
                else if (hit)
                begin
                    fix_q.push_back(pred);
                end
            end
            if (m_tvalid && m_tready)
            begin
                moved           = 1'b1;
                seen.latitude   = m_tdata[LAT_W-1:0];
                seen.longitude  = m_tdata[LAT_W+LON_W-1:LAT_W];
                seen.height_msl = m_tdata[FIELD_W-1:LAT_W+LON_W];
                seen.fix_ok     = m_tuser;
                if (fix_q.size() == 0)
                    report_mismatch("word with nothing expected", seen.longitude, '0);
                else
                begin
                    want = fix_q.pop_front();
                    if (seen.latitude !== want.latitude)
                        report_mismatch("latitude", 32'(seen.latitude), 32'(want.latitude));
                    if (seen.longitude !== want.longitude)
                        report_mismatch("longitude", seen.longitude, want.longitude);
                    if (seen.height_msl !== want.height_msl)
                        report_mismatch("height_msl", seen.height_msl, want.height_msl);
                    if (seen.fix_ok !== want.fix_ok)
                        report_mismatch("fix_ok", 32'(seen.fix_ok), 32'(want.fix_ok));
                    if (m_tdata[TDATA_W-1:FIELD_W] !== '0)
                        report_mismatch("tdata pad", 32'(m_tdata[TDATA_W-1:FIELD_W]), '0);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        stim_row_t rr;
        int        pick;
        int        sent_bytes;
        int        j;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        drv_typed   = 1'b0;
        drv_last    = 1'b0;
        drv_exp_hit = 1'b0;
        drv_exp     = '0;
        sent_bytes  = 0;
        hdr_set     = '{UBX_SYNC_1, UBX_SYNC_2, UBX_CLASS_NAV, UBX_ID_POS, UBX_ID_STATUS};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // kind, lead, n_lead, lat, lon, hgt, fix type, flags, length, check,
        // typed, result, latitude out, fix_ok out
        // fix flag still clear after reset
        add_row(FR_POS, '0, 0, '0, '0, '0, '0, '0, POS_LEN_FIELD, CK_GOOD,
                1, 1, '0, 0);
        // range extremes
        add_row(FR_POS, '0, 0, 32'h35A4_E900, 32'h94B6_2E00, 32'h7FFF_FFFF, '0, '0,
                POS_LEN_FIELD, CK_GOOD, 1, 1, 31'h35A4_E900, 0);
        add_row(FR_POS, '0, 0, 32'hCA5B_1700, 32'h6B49_D200, 32'h8000_0000, '0, '0,
                POS_LEN_FIELD, CK_GOOD, 1, 1, 31'h4A5B_1700, 0);
        // status frames: fix type and flag bit 0 decide the fix flag
        add_row(FR_STATUS, '0, 0, '0, '0, '0, FIX_3D, 8'h01, STAT_LEN_FIELD, CK_GOOD,
                1, 0, '0, 0);
        add_row(FR_POS, '0, 0, 32'h1, 32'h2, 32'h3, '0, '0, POS_LEN_FIELD, CK_GOOD,
                1, 1, 31'h1, 1);
        add_row(FR_STATUS, '0, 0, '0, '0, '0, FIX_3D, 8'hFE, STAT_LEN_FIELD, CK_GOOD,
                1, 0, '0, 0);
        add_row(FR_POS, '0, 0, 32'h4, 32'h5, 32'h6, '0, '0, POS_LEN_FIELD, CK_GOOD,
                1, 1, 31'h4, 0);
        add_row(FR_STATUS, '0, 0, '0, '0, '0, FIX_2D, 8'hFF, STAT_LEN_FIELD, CK_GOOD,
                1, 0, '0, 0);
        add_row(FR_POS, '0, 0, 32'h7, 32'h8, 32'h9, '0, '0, POS_LEN_FIELD, CK_GOOD,
                1, 1, 31'h7, 1);
        add_row(FR_STATUS, '0, 0, '0, '0, '0, FIX_NONE, 8'h01, STAT_LEN_FIELD, CK_GOOD,
                1, 0, '0, 0);
        add_row(FR_STATUS, '0, 0, '0, '0, '0, FIX_GNSS_DR, 8'h01, STAT_LEN_FIELD, CK_GOOD,
                1, 0, '0, 0);
        add_row(FR_STATUS, '0, 0, '0, '0, '0, FIX_TIME_ONLY, 8'h01, STAT_LEN_FIELD,
                CK_GOOD, 1, 0, '0, 0);
        add_row(FR_STATUS, '0, 0, '0, '0, '0, 8'hFF, 8'h01, STAT_LEN_FIELD, CK_GOOD,
                1, 0, '0, 0);
        add_row(FR_POS, '0, 0, 32'hA, 32'hB, 32'hC, '0, '0, POS_LEN_FIELD, CK_GOOD,
                1, 1, 31'hA, 0);
        // failed check leaves the fix flag alone
        add_row(FR_STATUS, '0, 0, '0, '0, '0, FIX_GNSS_DR, 8'h01, STAT_LEN_FIELD, CK_GOOD,
                1, 0, '0, 0);
        add_row(FR_STATUS, '0, 0, '0, '0, '0, FIX_NONE, 8'h00, STAT_LEN_FIELD, CK_BAD_A,
                1, 0, '0, 0);
        add_row(FR_STATUS, '0, 0, '0, '0, '0, FIX_NONE, 8'h00, STAT_LEN_FIELD, CK_BAD_B,
                1, 0, '0, 0);
        add_row(FR_POS, '0, 0, 32'hD, 32'hE, 32'hF, '0, '0, POS_LEN_FIELD, CK_GOOD,
                1, 1, 31'hD, 1);
        // failed check drops a position frame
        add_row(FR_POS, '0, 0, 32'h1, 32'h1, 32'h1, '0, '0, POS_LEN_FIELD, CK_BAD_A,
                1, 0, '0, 0);
        add_row(FR_POS, '0, 0, 32'h1, 32'h1, 32'h1, '0, '0, POS_LEN_FIELD, CK_BAD_B,
                1, 0, '0, 0);
        add_row(FR_POS, '0, 0, 32'h1, 32'h1, 32'h1, '0, '0, POS_LEN_FIELD, CK_BAD_BOTH,
                1, 0, '0, 0);
        // length field ignored; latitude top bit lost
        add_row(FR_POS, '0, 0, 32'h7FFF_FFFF, 32'h10, 32'h20, '0, '0, 16'hFFFF, CK_GOOD,
                1, 1, 31'h7FFF_FFFF, 1);
        add_row(FR_POS, '0, 0, 32'h8000_0000, 32'h30, 32'h40, '0, '0, 16'h0000, CK_GOOD,
                1, 1, 31'h0, 1);
        // broken headers: the mismatching byte is not taken as a new sync byte
        add_row(FR_POS, {24'h0, UBX_SYNC_1}, 1, 32'h50, 32'h60, 32'h70, '0, '0,
                POS_LEN_FIELD, CK_GOOD, 0, 0, '0, 0);
        add_row(FR_POS, {8'h0, JUNK_CLASS, UBX_SYNC_2, UBX_SYNC_1}, 3, 32'h51, 32'h61,
                32'h71, '0, '0, POS_LEN_FIELD, CK_GOOD, 0, 0, '0, 0);
        add_row(FR_POS, {JUNK_ID, UBX_CLASS_NAV, UBX_SYNC_2, UBX_SYNC_1}, 4, 32'h52,
                32'h62, 32'h72, '0, '0, POS_LEN_FIELD, CK_GOOD, 0, 0, '0, 0);

        foreach (dir_rows[i])
        begin
            play_row(dir_rows[i], 1'b0);
            sent_bytes += tx_bytes.size();
        end

        // Random traffic: mostly well-formed frames, some broken ones and noise
        while (sent_bytes < TOTAL_BYTES)
        begin
            pick         = $urandom_range(0, 99);
            rr.kind      = ($urandom_range(0, 1) == 0) ? FR_POS : FR_STATUS;
            rr.lead      = '0;
            rr.n_lead    = 0;
            rr.lat       = rand_word();
            rr.lon       = rand_word();
            rr.hgt       = rand_word();
            rr.fix_type  = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, 5));
            rr.flags     = 8'($urandom);
            rr.fault     = CK_GOOD;
            rr.typed     = 1'b0;
            rr.exp_hit   = 1'b0;
            rr.exp_lat   = '0;
            rr.exp_fix   = 1'b0;
            if (pick < 45)
                rr.kind = FR_POS;
            else if (pick < 72)
                rr.kind = FR_STATUS;
            else if (pick < 84)
                rr.fault = ck_fault_t'($urandom_range(1, 3));
            else if (pick < 93)
            begin
                // header cut short by a random byte
                rr.n_lead = $urandom_range(1, 4);
                rr.lead   = {hdr_set[$urandom_range(3, 4)], UBX_CLASS_NAV, UBX_SYNC_2,
                             UBX_SYNC_1};
                rr.lead[8*(rr.n_lead-1) +: 8] = 8'($urandom);
            end
            else
            begin
                rr.kind   = FR_NONE;
                rr.n_lead = $urandom_range(1, 4);
                for (j = 0; j < 4; j++)
                    rr.lead[8*j +: 8] = ($urandom_range(0, 1) == 0) ? 8'($urandom)
                                                                    : hdr_set[$urandom_range(0, 4)];
            end
            rr.len_field = (rr.kind == FR_POS) ? POS_LEN_FIELD : STAT_LEN_FIELD;
            if ($urandom_range(0, 7) == 0)
                rr.len_field = 16'($urandom);
            play_row(rr, 1'b1);
            sent_bytes += tx_bytes.size();
        end

        s_tvalid <= 1'b0;
        while (fix_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== ubx_nav_position_deframer_core.f =====
+incdir+src
src/ubxnav_pkg.sv
src/ubxnav_parser.sv
src/ubx_nav_position_deframer_core.sv
dv/ubx_nav_position_deframer_core_tb.sv
